### src/cdt_pkg.sv
// ----------------------------------------------------------------------------
// Countdown timer table package
// Shared widths, command and result codes, and the slot unit result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdt_pkg;

  // Default number of timer slots.
  localparam int unsigned MaxTimersDefault = 16;

  // Fixed field widths.
  localparam int unsigned CmdW   = 2;
  localparam int unsigned IdW    = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned KindW  = 3;

  // Command codes.
  localparam logic [CmdW-1:0] CmdAdd  = 2'd0;
  localparam logic [CmdW-1:0] CmdStop = 2'd1;
  localparam logic [CmdW-1:0] CmdTick = 2'd2;

  // Result kinds.
  localparam logic [KindW-1:0] KindAdded   = 3'd0;
  localparam logic [KindW-1:0] KindFull    = 3'd1;
  localparam logic [KindW-1:0] KindStopped = 3'd2;
  localparam logic [KindW-1:0] KindExpired = 3'd3;
  localparam logic [KindW-1:0] KindIdle    = 3'd4;

  // Verdict of the slot unit for one table entry.
  typedef struct packed {
    logic              keep;
    logic              expire;
    logic [CountW-1:0] count;
  } slot_verdict_t;

endpackage : cdt_pkg

`default_nettype wire

### src/cdt_slot_alu.sv
// ----------------------------------------------------------------------------
// Countdown timer slot unit
// Shared compare and decrement unit applied to one table entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdt_slot_alu import cdt_pkg::*; (
  input  wire logic              tick_i,
  input  wire logic [IdW-1:0]    key_i,
  input  wire logic [IdW-1:0]    slot_id_i,
  input  wire logic [CountW-1:0] slot_count_i,
  output slot_verdict_t          verdict_o
);

  logic at_end;

  // A count of zero or one runs out on this tick.
  assign at_end = (slot_count_i[CountW-1:1] == '0);

  always_comb begin
    verdict_o.count = slot_count_i - CountW'(1);
    if (tick_i) begin
      verdict_o.expire = at_end;
      verdict_o.keep   = !at_end;
    end else begin
      verdict_o.expire = 1'b0;
      verdict_o.keep   = (slot_id_i != key_i);
    end
  end

endmodule : cdt_slot_alu

`default_nettype wire

### src/countdown_timer_table.sv
// ----------------------------------------------------------------------------
// Countdown timer table
// A table of one-shot countdown timers kept in insertion order, with add,
// stop-by-identifier and tick commands; expiries are reported in table order.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Transfer when
//   --------  --------------------------------------  ------------------------
//   command   start, busy, command_i, timer_key_i,    start high, busy low
//             seconds_i
//   result    result_valid_o, kind_o, expired_id_o,   result_valid_o high
//             last_o                                  (one cycle, no stall)
//
// An add needs no walk of the table; its result appears on the following cycle.
// A stop or a tick walks the table with one shared compare/decrement unit
// through the single read port of the slot memory, and busy stays high until
// the walk is done. The final result appears as busy falls.
// Reset clears the fill count and the sequencer; the slot memory is not
// cleared, as only entries below the fill count are ever read.
// The receiver cannot stall: every result is presented for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module countdown_timer_table import cdt_pkg::*; #(
  parameter int unsigned MAX_TIMERS = MaxTimersDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CmdW-1:0]   command_i,
  input  wire logic [IdW-1:0]    timer_key_i,
  input  wire logic [CountW-1:0] seconds_i,
  output logic                   result_valid_o,
  output logic [KindW-1:0]       kind_o,
  output logic [IdW-1:0]         expired_id_o,
  output logic                   last_o
);

  // Index width addresses the slots; the fill count must also hold MAX_TIMERS.
  localparam int unsigned IdxW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TIMERS + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(MAX_TIMERS);

  // Sequencer states.
  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StWalk = 1'b1;

  // Slot memory: identifier and remaining count per entry.
  logic [IdW-1:0]    slot_id_mem    [MAX_TIMERS];
  logic [CountW-1:0] slot_count_mem [MAX_TIMERS];

  logic [0:0]        state_q, state_d;
  logic              tick_q, tick_d;
  logic [IdW-1:0]    key_q, key_d;
  logic [CntW-1:0]   occ_q, occ_d;
  logic [CntW-1:0]   rd_q, rd_d;
  logic [CntW-1:0]   wr_q, wr_d;
  logic              rv_q, rv_d;
  logic              pend_q, pend_d;
  logic [IdW-1:0]    pend_id_q, pend_id_d;
  logic              res_valid_q, res_valid_d;
  logic [KindW-1:0]  res_kind_q, res_kind_d;
  logic [IdW-1:0]    res_id_q, res_id_d;
  logic              res_last_q, res_last_d;

  logic [IdW-1:0]    rdata_id_q;
  logic [CountW-1:0] rdata_count_q;

  // Memory port controls.
  logic              rd_en;
  logic              wr_en;
  logic [IdxW-1:0]   wr_idx;
  logic [IdW-1:0]    wr_id;
  logic [CountW-1:0] wr_count;

  logic              accept;
  logic              walk_done;
  slot_verdict_t     verdict;

  assign accept    = start && (state_q == StIdle);
  assign rd_en     = (state_q == StWalk) && (rd_q != occ_q);
  assign walk_done = (state_q == StWalk) && !rd_en && !rv_q;

  // The one shared unit judges the entry that was read in the previous cycle.
  cdt_slot_alu u_alu (
    .tick_i       (tick_q),
    .key_i        (key_q),
    .slot_id_i    (rdata_id_q),
    .slot_count_i (rdata_count_q),
    .verdict_o    (verdict)
  );

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    key_d       = key_q;
    occ_d       = occ_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    rv_d        = 1'b0;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    res_valid_d = 1'b0;
    res_kind_d  = res_kind_q;
    res_id_d    = res_id_q;
    res_last_d  = 1'b1;
    wr_en       = 1'b0;
    wr_idx      = wr_q[IdxW-1:0];
    wr_id       = rdata_id_q;
    wr_count    = verdict.count;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (command_i)
            CmdAdd: begin
              res_valid_d = 1'b1;
              res_id_d    = timer_key_i;
              if (occ_q == FullCount) begin
                res_kind_d = KindFull;
              end else begin
                res_kind_d = KindAdded;
                wr_en      = 1'b1;
                wr_idx     = occ_q[IdxW-1:0];
                wr_id      = timer_key_i;
                wr_count   = seconds_i;
                occ_d      = occ_q + CntW'(1);
              end
            end
            CmdStop, CmdTick: begin
              // The walk starts at slot zero and compacts in place.
              state_d = StWalk;
              tick_d  = (command_i == CmdTick);
              key_d   = timer_key_i;
              rd_d    = '0;
              wr_d    = '0;
              pend_d  = 1'b0;
            end
            default: begin
              // The unused command code is dropped without a result.
            end
          endcase
        end
      end
      StWalk: begin
        if (rd_en) begin
          rv_d = 1'b1;
          rd_d = rd_q + CntW'(1);
        end
        if (rv_q) begin
          if (verdict.keep) begin
            wr_en = 1'b1;
            wr_d  = wr_q + CntW'(1);
            if (!tick_q) begin
              wr_count = rdata_count_q;
            end
          end
          if (verdict.expire) begin
            // Each expiry is held back one step so that the final one can
            // carry the last flag.
            if (pend_q) begin
              res_valid_d = 1'b1;
              res_kind_d  = KindExpired;
              res_id_d    = pend_id_q;
              res_last_d  = 1'b0;
            end
            pend_d    = 1'b1;
            pend_id_d = rdata_id_q;
          end
        end
        if (walk_done) begin
          state_d     = StIdle;
          occ_d       = wr_q;
          res_valid_d = 1'b1;
          if (!tick_q) begin
            res_kind_d = KindStopped;
            res_id_d   = key_q;
          end else if (pend_q) begin
            res_kind_d = KindExpired;
            res_id_d   = pend_id_q;
          end else begin
            res_kind_d = KindIdle;
            res_id_d   = '0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      occ_q       <= '0;
      rv_q        <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rv_q        <= rv_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    tick_q     <= tick_d;
    key_q      <= key_d;
    rd_q       <= rd_d;
    wr_q       <= wr_d;
    pend_id_q  <= pend_id_d;
    res_kind_q <= res_kind_d;
    res_id_q   <= res_id_d;
    res_last_q <= res_last_d;
  end

  // Slot memory write port. The write slot never passes the read slot, so
  // entries not yet read are never overwritten.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_id_mem[wr_idx]    <= wr_id;
      slot_count_mem[wr_idx] <= wr_count;
    end
  end

  // Slot memory read port with registered data.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_id_q    <= slot_id_mem[rd_q[IdxW-1:0]];
      rdata_count_q <= slot_count_mem[rd_q[IdxW-1:0]];
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign kind_o         = res_kind_q;
  assign expired_id_o   = res_id_q;
  assign last_o         = res_last_q;

  // The fill count never exceeds the table size.
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FullCount)
    else $error("fill count exceeds table size");

  // Compaction never writes ahead of the read pointer.
  a_wr_behind_rd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (wr_q <= rd_q))
    else $error("compaction write pointer passed read pointer");

  // A walk ends with its final result.
  a_walk_ends_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && last_o))
    else $error("walk ended without a final result");

  // A non-final result only appears while a walk is still running.
  a_nonlast_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> (busy && kind_o == KindExpired))
    else $error("non-final result outside a tick walk");

  // An add to a full table reports full on the next cycle.
  a_full_report : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CmdAdd && occ_q == FullCount)
      |=> (result_valid_o && kind_o == KindFull && occ_q == FullCount))
    else $error("add to full table not reported");

endmodule : countdown_timer_table

`default_nettype wire
